### rtl/paged_frame_allocator_translator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the paged frame allocator / translator
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PAGED_FRAME_ALLOCATOR_TRANSLATOR_UNIT_DEFINES_SVH
`define PAGED_FRAME_ALLOCATOR_TRANSLATOR_UNIT_DEFINES_SVH

// Expression must hold at every edge out of reset.
`define PFAT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PFAT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pfat_pkg.sv
// ----------------------------------------------------------------------------
// pfat_pkg
// Types, codes and constants shared by the frame allocator / translator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfat_pkg;

	localparam int MAX_FRAMES_DEF    = 64;
	localparam int MAX_PAGE_SIZE     = 4096;

	localparam int PAGE_SIZE_W       = 13;
	localparam int MEMORY_SIZE_W     = 19;
	localparam int JOB_ID_W          = 16;
	localparam int JOB_SIZE_W        = 19;
	localparam int LOC_W             = 18;

	localparam int RESET_PAGE_SIZE   = 100;
	localparam int RESET_MEMORY_SIZE = 1000;

	// one restoring step per dividend bit
	localparam int DIV_STEPS         = JOB_SIZE_W;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);

	localparam int CFG_INDEX_W       = 1;
	localparam int CFG_DATA_W        = MEMORY_SIZE_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAGE_SIZE   = 1'd0,
		REG_MEMORY_SIZE = 1'd1
	} cfg_reg_t;

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_NO_FRAMES    = 2'd1;
	localparam logic [1:0] STATUS_BAD_LOCATION = 2'd2;
	localparam logic [1:0] STATUS_NO_JOB       = 2'd3;

	localparam logic MODE_LOAD      = 1'b0;
	localparam logic MODE_TRANSLATE = 1'b1;

	// input beat, first field in the highest bits
	typedef struct packed {
		logic [LOC_W-1:0]      byte_location;
		logic [JOB_SIZE_W-1:0] job_size;
		logic [JOB_ID_W-1:0]   job_id;
	} item_t;

	localparam int ITEM_W      = $bits(item_t);
	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;

	// result beat, first field in the highest bits
	typedef struct packed {
		logic [6:0]  used_frames;
		logic [17:0] physical_address;
		logic [5:0]  frame_number;
		logic [11:0] page_offset;
		logic [5:0]  page_number;
		logic [6:0]  free_frames;
		logic [11:0] fragmentation;
		logic [6:0]  page_count;
		logic [1:0]  status;
	} res_t;

	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic                   start;
		logic [JOB_SIZE_W-1:0]  dividend;
		logic [PAGE_SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [JOB_SIZE_W-1:0]  quotient;
		logic [PAGE_SIZE_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CFG_START,
		ST_CFG_WAIT,
		ST_LD_WAIT,
		ST_TR_WAIT,
		ST_TR_MUL,
		ST_EMIT
	} state_t;

	// zero reads as one byte, oversize clamps to the largest page
	function automatic logic [PAGE_SIZE_W-1:0] eff_page_size(
		input logic [PAGE_SIZE_W-1:0] ps
	);
		logic [PAGE_SIZE_W-1:0] r;
		if (ps == '0) begin
			r = PAGE_SIZE_W'(1);
		end else if (32'(ps) > MAX_PAGE_SIZE) begin
			r = PAGE_SIZE_W'(MAX_PAGE_SIZE);
		end else begin
			r = ps;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/pfat_div.sv
// ----------------------------------------------------------------------------
// pfat_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfat_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pfat_pkg::div_req_t req,
	output pfat_pkg::div_rsp_t      rsp
);

	`include "paged_frame_allocator_translator_unit_defines.svh"

	logic                                active_q;
	logic                                done_q;
	logic [pfat_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [pfat_pkg::JOB_SIZE_W-1:0]     quo_q;
	logic [pfat_pkg::PAGE_SIZE_W-1:0]    rem_q;
	logic [pfat_pkg::PAGE_SIZE_W-1:0]    div_q;

	logic [pfat_pkg::PAGE_SIZE_W:0]      shifted;
	logic [pfat_pkg::PAGE_SIZE_W+1:0]    diff;
	logic                                neg;

	assign shifted = {rem_q, quo_q[pfat_pkg::JOB_SIZE_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};
	assign neg     = diff[pfat_pkg::PAGE_SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (req.start) begin
			active_q <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= pfat_pkg::DIV_CNT_W'(pfat_pkg::DIV_STEPS);
		end else if (active_q) begin
			active_q <= (cnt_q != pfat_pkg::DIV_CNT_W'(1));
			done_q   <= (cnt_q == pfat_pkg::DIV_CNT_W'(1));
			cnt_q    <= cnt_q - pfat_pkg::DIV_CNT_W'(1);
		end else begin
			done_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (active_q) begin
			// keep the trial difference when it does not go negative
			quo_q <= {quo_q[pfat_pkg::JOB_SIZE_W-2:0], ~neg};
			rem_q <= neg ? shifted[pfat_pkg::PAGE_SIZE_W-1:0]
			             : diff[pfat_pkg::PAGE_SIZE_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`PFAT_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "divider done held longer than one cycle")
	`PFAT_ASSERT_IMPL(a_div_rem_range, done_q, rem_q < div_q, "divider remainder not below divisor")

endmodule

`default_nettype wire

### rtl/paged_frame_allocator_translator_unit.sv
// ----------------------------------------------------------------------------
// paged_frame_allocator_translator_unit
// Frame allocator for one current job and job-relative address translator.
// ----------------------------------------------------------------------------
// One item at a time. A load waits on the shared divider, and a translate
// waits on it and then on a multiply state; the divider produces one
// quotient bit per cycle over the 19-bit dividend. A translate that finds
// no job or a byte past the job size skips the divider and goes straight to
// the emit state. Each configuration write starts the same divider on the
// usable-frame count (memory size over page size), and s_tready stays low
// until that division ends after the last write. A finished result sits
// in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_frame_allocator_translator_unit #(
	parameter int MAX_FRAMES = pfat_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// job_id[15:0], job_size[34:16], byte_location[52:35], zero pad
	input  wire logic [pfat_pkg::IN_TDATA_W-1:0]     s_tdata,
	// mode[0]
	input  wire logic                                s_tuser,

	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// status[1:0], page_count[8:2], fragmentation[20:9], free_frames[27:21],
	// page_number[33:28], page_offset[45:34], frame_number[51:46],
	// physical_address[69:52], used_frames[76:70], zero pad
	output logic [pfat_pkg::OUT_TDATA_W-1:0]         m_tdata,

	// configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [pfat_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [pfat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	`include "paged_frame_allocator_translator_unit_defines.svh"

	localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int RESET_USABLE =
		(pfat_pkg::RESET_MEMORY_SIZE / pfat_pkg::RESET_PAGE_SIZE > MAX_FRAMES)
		? MAX_FRAMES : pfat_pkg::RESET_MEMORY_SIZE / pfat_pkg::RESET_PAGE_SIZE;
	localparam int PAGES_W = pfat_pkg::JOB_SIZE_W + 1;

	// Frames only ever fill from frame zero upward and are released all at
	// once by a configuration write, so the busy frames are always the run
	// [0, used_q). A load takes frames used_q .. used_q + pages - 1, and page
	// p of the current job sits in frame base_q + p.

	pfat_pkg::state_t                       state_q, state_d;
	pfat_pkg::item_t                        item;
	pfat_pkg::div_req_t                     div_req;
	pfat_pkg::div_rsp_t                     div_rsp;
	pfat_pkg::res_t                         res_q;
	pfat_pkg::res_t                         res_d;
	pfat_pkg::res_t                         out_q;

	logic                                   m_tvalid_q;
	logic [pfat_pkg::PAGE_SIZE_W-1:0]       eff_ps_q;
	logic [pfat_pkg::MEMORY_SIZE_W-1:0]     memory_size_q;
	logic [FRAME_CNT_W-1:0]                 usable_q;
	logic [FRAME_CNT_W-1:0]                 used_q;
	logic [FRAME_CNT_W-1:0]                 base_q;
	logic                                   job_loaded_q;
	logic [pfat_pkg::JOB_SIZE_W-1:0]        job_size_q;
	logic [FRAME_CNT_W-1:0]                 fr_q;
	logic [pfat_pkg::PAGE_SIZE_W-1:0]       off_q;

	logic                                   accept;
	logic                                   is_load;
	logic                                   tr_in_range;
	logic                                   emit_fire;
	logic                                   div_wait;
	logic [PAGES_W-1:0]                     pages;
	logic [FRAME_CNT_W-1:0]                 free_cnt;
	logic                                   load_ok;
	logic [FRAME_CNT_W-1:0]                 used_next;
	logic [FRAME_CNT_W-1:0]                 fr_next;
	logic [FRAME_CNT_W+pfat_pkg::PAGE_SIZE_W-1:0] prod;
	logic [pfat_pkg::JOB_SIZE_W-1:0]        usable_quo;

	assign item        = s_tdata[pfat_pkg::ITEM_W-1:0];
	assign accept      = s_tvalid && s_tready;
	assign is_load     = (s_tuser == pfat_pkg::MODE_LOAD);
	assign tr_in_range = job_loaded_q && ({1'b0, item.byte_location} < job_size_q);
	assign emit_fire   = (state_q == pfat_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);

	// states in which the divider may report done
	assign div_wait = (state_q == pfat_pkg::ST_CFG_START)
	               || (state_q == pfat_pkg::ST_CFG_WAIT)
	               || (state_q == pfat_pkg::ST_LD_WAIT)
	               || (state_q == pfat_pkg::ST_TR_WAIT);

	// load arithmetic, valid while the divider reports done in ST_LD_WAIT
	assign pages     = {1'b0, div_rsp.quotient} + PAGES_W'(div_rsp.remainder != '0);
	assign free_cnt  = usable_q - used_q;
	assign load_ok   = (pages <= PAGES_W'(free_cnt));
	assign used_next = load_ok ? used_q + FRAME_CNT_W'(pages) : used_q;

	// translate: frame of the page, then frame times page size
	assign fr_next = base_q + FRAME_CNT_W'(div_rsp.quotient);
	assign prod    = fr_q * eff_ps_q;

	// quotient as the usable-frame count, capped at the table depth when stored
	assign usable_quo = div_rsp.quotient;

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = pfat_pkg::ST_CFG_START;
		end else begin
			unique case (state_q)
				pfat_pkg::ST_IDLE: begin
					if (accept) begin
						if (is_load) begin
							state_d = pfat_pkg::ST_LD_WAIT;
						end else if (tr_in_range) begin
							state_d = pfat_pkg::ST_TR_WAIT;
						end else begin
							state_d = pfat_pkg::ST_EMIT;
						end
					end
				end
				pfat_pkg::ST_CFG_START: state_d = pfat_pkg::ST_CFG_WAIT;
				pfat_pkg::ST_CFG_WAIT: begin
					if (div_rsp.done) state_d = pfat_pkg::ST_IDLE;
				end
				pfat_pkg::ST_LD_WAIT: begin
					if (div_rsp.done) state_d = pfat_pkg::ST_EMIT;
				end
				pfat_pkg::ST_TR_WAIT: begin
					if (div_rsp.done) state_d = pfat_pkg::ST_TR_MUL;
				end
				pfat_pkg::ST_TR_MUL: state_d = pfat_pkg::ST_EMIT;
				pfat_pkg::ST_EMIT: begin
					if (emit_fire) state_d = pfat_pkg::ST_IDLE;
				end
				default: state_d = pfat_pkg::ST_IDLE;
			endcase
		end
	end

	// Drive the handshake and the divider request from the state.
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = item.job_size;
		div_req.divisor  = eff_ps_q;
		unique case (state_q)
			pfat_pkg::ST_IDLE: begin
				// hold off an item in the cycle of a register write
				s_tready = !cfg_we;
				if (is_load) begin
					div_req.dividend = item.job_size;
				end else begin
					div_req.dividend = {1'b0, item.byte_location};
				end
				div_req.start = accept && (is_load || tr_in_range);
			end
			pfat_pkg::ST_CFG_START: begin
				div_req.dividend = memory_size_q;
				div_req.start    = 1'b1;
			end
			pfat_pkg::ST_CFG_WAIT,
			pfat_pkg::ST_LD_WAIT,
			pfat_pkg::ST_TR_WAIT,
			pfat_pkg::ST_TR_MUL,
			pfat_pkg::ST_EMIT: begin
				s_tready = 1'b0;
			end
			default: s_tready = 1'b0;
		endcase
	end

	pfat_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pfat_pkg::ST_IDLE;
			m_tvalid_q    <= 1'b0;
			eff_ps_q      <= pfat_pkg::PAGE_SIZE_W'(pfat_pkg::RESET_PAGE_SIZE);
			memory_size_q <= pfat_pkg::MEMORY_SIZE_W'(pfat_pkg::RESET_MEMORY_SIZE);
			usable_q      <= FRAME_CNT_W'(RESET_USABLE);
			used_q        <= '0;
			job_loaded_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_we) begin
				// any write frees every frame and drops the job
				unique case (pfat_pkg::cfg_reg_t'(cfg_index))
					pfat_pkg::REG_PAGE_SIZE: begin
						eff_ps_q <= pfat_pkg::eff_page_size(
							cfg_wdata[pfat_pkg::PAGE_SIZE_W-1:0]);
					end
					pfat_pkg::REG_MEMORY_SIZE: begin
						memory_size_q <= cfg_wdata;
					end
					default: memory_size_q <= memory_size_q;
				endcase
				used_q       <= '0;
				job_loaded_q <= 1'b0;
			end else begin
				if (state_q == pfat_pkg::ST_CFG_WAIT && div_rsp.done) begin
					if (32'(usable_quo) > 32'(MAX_FRAMES)) begin
						usable_q <= FRAME_CNT_W'(MAX_FRAMES);
					end else begin
						usable_q <= FRAME_CNT_W'(usable_quo);
					end
				end
				if (state_q == pfat_pkg::ST_LD_WAIT && div_rsp.done) begin
					used_q       <= used_next;
					job_loaded_q <= load_ok;
				end
			end
		end
	end

	// ---------------------------------------------------------- payload
	// Build the next result: clear it on accept, then fill in the load or
	// translate fields as the divider and the multiplier finish.
	always_comb begin
		res_d = res_q;
		if (state_q == pfat_pkg::ST_IDLE && accept) begin
			res_d             = '0;
			res_d.used_frames = 7'(used_q);
			if (!is_load) begin
				if (!job_loaded_q) begin
					res_d.status = pfat_pkg::STATUS_NO_JOB;
				end else if (!tr_in_range) begin
					res_d.status = pfat_pkg::STATUS_BAD_LOCATION;
				end
			end
		end

		if (state_q == pfat_pkg::ST_LD_WAIT && div_rsp.done) begin
			res_d.status        = load_ok ? pfat_pkg::STATUS_OK
			                              : pfat_pkg::STATUS_NO_FRAMES;
			res_d.page_count    = (pages > PAGES_W'(127)) ? 7'd127 : 7'(pages);
			res_d.fragmentation = (div_rsp.remainder != '0)
			                      ? 12'(eff_ps_q - div_rsp.remainder) : 12'd0;
			res_d.free_frames   = 7'(free_cnt);
			res_d.used_frames   = 7'(used_next);
		end

		if (state_q == pfat_pkg::ST_TR_WAIT && div_rsp.done) begin
			res_d.page_number  = 6'(div_rsp.quotient);
			res_d.page_offset  = 12'(div_rsp.remainder);
			res_d.frame_number = 6'(fr_next);
		end

		if (state_q == pfat_pkg::ST_TR_MUL) begin
			res_d.physical_address = 18'(prod) + 18'(off_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfat_pkg::ST_IDLE && accept && is_load) begin
			job_size_q <= item.job_size;
			base_q     <= used_q;
		end

		res_q <= res_d;

		if (state_q == pfat_pkg::ST_TR_WAIT && div_rsp.done) begin
			fr_q  <= fr_next;
			off_q <= div_rsp.remainder;
		end

		if (emit_fire) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(pfat_pkg::OUT_TDATA_W - pfat_pkg::RES_W)'(0), out_q};

	`PFAT_ASSERT_ALWAYS(a_used_le_usable, used_q <= usable_q, "more frames used than usable")
	`PFAT_ASSERT_NEXT(a_cfg_clears, cfg_we, (used_q == '0) && !job_loaded_q, "write left frames")
	`PFAT_ASSERT_IMPL(a_div_done_state, div_rsp.done, div_wait, "divider done outside a wait")

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged frame allocator and address translator.
// It drives load and translate beats over the input stream and writes the
// page size and memory size registers between phases. Each accepted beat is
// run through a local copy of the frame table to form the expected reply,
// and each reply beat is compared field by field with the oldest of those.
// Directed cases come first: reset values, size-zero jobs, exact fits, failed
// loads, clamped page sizes and saturated page counts. A long output stall
// follows, then random phases of well-formed job traffic with some noise,
// and finally a stretch with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;     // longest divider pass plus margin
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_ITEMS  = 640;
	localparam int STEADY_ITEMS  = 60;
	localparam int TABLE_DEPTH   = pfat_pkg::MAX_FRAMES_DEF;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [pfat_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [pfat_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_we;
	pfat_pkg::cfg_reg_t               cfg_index;
	logic [pfat_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	// Local copy of the block's state
	logic [pfat_pkg::PAGE_SIZE_W-1:0]   cfg_page_size;
	logic [pfat_pkg::MEMORY_SIZE_W-1:0] cfg_mem_size;
	bit                                 frame_taken [TABLE_DEPTH];
	int unsigned                        page_to_frame [TABLE_DEPTH];
	int unsigned                        frame_limit;
	int unsigned                        job_bytes;
	bit                                 job_present;

	// Replies predicted for accepted beats, oldest first
	pfat_pkg::res_t frame_reply_q [$];

	// Run control and bookkeeping
	bit          sender_gaps;
	bit          receiver_stalls;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned loads_sent;
	int unsigned translates_sent;
	int unsigned cfg_writes;
	int unsigned random_sent;
	int unsigned status_seen [4];

	paged_frame_allocator_translator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("paged_frame_allocator_translator_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Frame table model
	// ------------------------------------------------------------------------

	// Zero means one byte, anything past the largest page clamps to it
	function automatic int unsigned page_bytes(
		input logic [pfat_pkg::PAGE_SIZE_W-1:0] ps
	);
		if (ps == '0)
			return 1;
		if (ps > pfat_pkg::MAX_PAGE_SIZE)
			return pfat_pkg::MAX_PAGE_SIZE;
		return ps;
	endfunction

	function automatic int unsigned busy_frames();
		int unsigned n;
		n = 0;
		for (int i = 0; i < frame_limit; i++)
			if (frame_taken[i])
				n++;
		return n;
	endfunction

	// Any register write recomputes the frame count, frees all frames and
	// drops the current job
	function automatic void rebuild_frames();
		int unsigned n;
		n = cfg_mem_size / page_bytes(cfg_page_size);
		frame_limit = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
		for (int i = 0; i < TABLE_DEPTH; i++)
			frame_taken[i] = 1'b0;
		job_present = 1'b0;
	endfunction

	function automatic pfat_pkg::res_t allocate_or_translate(
		input logic                            mode,
		input logic [pfat_pkg::JOB_SIZE_W-1:0] size,
		input logic [pfat_pkg::LOC_W-1:0]      loc
	);
		pfat_pkg::res_t r;
		int unsigned    ps, pages, rem, freec, p, pg, off, fr;
		r  = '0;
		ps = page_bytes(cfg_page_size);
		if (mode == pfat_pkg::MODE_LOAD) begin
			pages = (size + ps - 1) / ps;
			rem   = size % ps;
			freec = frame_limit - busy_frames();
			job_bytes = size;
			r.page_count    = (pages > 127) ? 7'd127 : 7'(pages);
			r.fragmentation = (rem != 0) ? 12'(ps - rem) : 12'd0;
			r.free_frames   = 7'(freec);
			if (pages > freec) begin
				r.status    = pfat_pkg::STATUS_NO_FRAMES;
				job_present = 1'b0;
			end else begin
				// take free frames lowest first
				p = 0;
				for (int i = 0; i < frame_limit && p < pages; i++) begin
					if (!frame_taken[i]) begin
						frame_taken[i]   = 1'b1;
						page_to_frame[p] = i;
						p++;
					end
				end
				r.status    = pfat_pkg::STATUS_OK;
				job_present = 1'b1;
			end
		end else if (!job_present) begin
			r.status = pfat_pkg::STATUS_NO_JOB;
		end else if (loc >= job_bytes) begin
			r.status = pfat_pkg::STATUS_BAD_LOCATION;
		end else begin
			pg  = loc / ps;
			off = loc % ps;
			fr  = page_to_frame[pg % TABLE_DEPTH];
			r.status           = pfat_pkg::STATUS_OK;
			r.page_number      = 6'(pg);
			r.page_offset      = 12'(off);
			r.frame_number     = 6'(fr);
			r.physical_address = 18'(fr * ps + off);
		end
		r.used_frames = 7'(busy_frames());
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Reply side: check each beat, then pick next cycle's tready
	// ------------------------------------------------------------------------

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : reply_side
		pfat_pkg::res_t want;
		pfat_pkg::res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_reply_q.size() == 0) begin
					$error("reply beat with no load or translate outstanding");
					fail_count++;
				end else begin
					want = frame_reply_q.pop_front();
					got  = pfat_pkg::res_t'(m_tdata[pfat_pkg::RES_W-1:0]);
					check_field("status",           want.status,           got.status);
					check_field("page_count",       want.page_count,       got.page_count);
					check_field("fragmentation",    want.fragmentation,    got.fragmentation);
					check_field("free_frames",      want.free_frames,      got.free_frames);
					check_field("page_number",      want.page_number,      got.page_number);
					check_field("page_offset",      want.page_offset,      got.page_offset);
					check_field("frame_number",     want.frame_number,     got.frame_number);
					check_field("physical_address", want.physical_address,
						got.physical_address);
					check_field("used_frames",      want.used_frames,      got.used_frames);
				end
			end
			// a requested long hold wins over the short random bursts
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one beat and hold it until accepted. Valid is only dropped when a
	// gap is taken, so it never falls and rises in the same step.
	task automatic send_item(
		input logic                            mode,
		input logic [pfat_pkg::JOB_ID_W-1:0]   id,
		input logic [pfat_pkg::JOB_SIZE_W-1:0] size,
		input logic [pfat_pkg::LOC_W-1:0]      loc
	);
		pfat_pkg::item_t beat;
		pfat_pkg::res_t  want;
		beat.job_id        = id;
		beat.job_size      = size;
		beat.byte_location = loc;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= pfat_pkg::IN_TDATA_W'(beat);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = allocate_or_translate(mode, size, loc);
		frame_reply_q.insert(frame_reply_q.size(), want);
		status_seen[want.status]++;
		if (mode == pfat_pkg::MODE_LOAD)
			loads_sent++;
		else
			translates_sent++;
	endtask

	// Drop valid, wait for every reply, then give the block time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pfat_pkg::cfg_reg_t idx,
			input logic [pfat_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pfat_pkg::REG_PAGE_SIZE)
			cfg_page_size = value[pfat_pkg::PAGE_SIZE_W-1:0];
		else
			cfg_mem_size = value;
		rebuild_frames();
		cfg_writes++;
	endtask

	// Pick a page size, then a memory size that lands on a chosen frame count
	// most of the time; write both in either order, or only one now and then
	task automatic pick_random_config();
		logic [pfat_pkg::PAGE_SIZE_W-1:0]   ps;
		logic [pfat_pkg::MEMORY_SIZE_W-1:0] mem;
		int unsigned                        sel, eff, order;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			ps = '0;
		else if (sel < 20)
			ps = pfat_pkg::PAGE_SIZE_W'($urandom_range(pfat_pkg::MAX_PAGE_SIZE + 1, 8191));
		else if (sel < 55)
			ps = pfat_pkg::PAGE_SIZE_W'($urandom_range(1, 64));
		else
			ps = pfat_pkg::PAGE_SIZE_W'($urandom_range(65, pfat_pkg::MAX_PAGE_SIZE));
		eff = page_bytes(ps);
		sel = $urandom_range(0, 99);
		if (sel < 6)
			mem = '0;
		else if (sel < 12)
			mem = '1;
		else if (sel < 25)
			mem = pfat_pkg::MEMORY_SIZE_W'($urandom);
		else
			mem = pfat_pkg::MEMORY_SIZE_W'($urandom_range(0, 72) * eff
				+ $urandom_range(0, eff - 1));
		order = $urandom_range(0, 19);
		// upper bits of the data word are random on page size writes
		if (order < 8) begin
			write_reg(pfat_pkg::REG_PAGE_SIZE, {6'($urandom), ps});
			write_reg(pfat_pkg::REG_MEMORY_SIZE, mem);
		end else if (order < 16) begin
			write_reg(pfat_pkg::REG_MEMORY_SIZE, mem);
			write_reg(pfat_pkg::REG_PAGE_SIZE, {6'($urandom), ps});
		end else if (order < 18) begin
			write_reg(pfat_pkg::REG_PAGE_SIZE, {6'($urandom), ps});
		end else begin
			write_reg(pfat_pkg::REG_MEMORY_SIZE, mem);
		end
	endtask

	// Mostly well-formed traffic: loads that fit or just miss the free
	// frames, translates inside the current job; plus some out-of-range and
	// fully random beats
	task automatic run_mixed_items(input int count);
		int unsigned ps, freec, pages, sel, hi, size, loc;
		for (int k = 0; k < count; k++) begin
			ps  = page_bytes(cfg_page_size);
			sel = $urandom_range(0, 99);
			if ((!job_present && sel < 85) || sel < 30) begin
				freec = frame_limit - busy_frames();
				if ($urandom_range(0, 9) < 8) begin
					sel = $urandom_range(0, 9);
					if (sel == 0)
						pages = freec + $urandom_range(1, 3);
					else if (sel < 3)
						pages = freec;
					else
						pages = $urandom_range(0, (freec < 8) ? freec : 8);
					size = (pages == 0) ? 0 : (pages - 1) * ps + $urandom_range(1, ps);
					if (size > 19'h7FFFF)
						size = 19'h7FFFF;
				end else begin
					size = $urandom_range(0, 19'h7FFFF);
				end
				send_item(pfat_pkg::MODE_LOAD, pfat_pkg::JOB_ID_W'($urandom),
					pfat_pkg::JOB_SIZE_W'(size), pfat_pkg::LOC_W'($urandom));
			end else begin
				if (job_present && job_bytes > 0 && sel < 90) begin
					hi  = (job_bytes - 1 > 18'h3FFFF) ? 18'h3FFFF : job_bytes - 1;
					loc = $urandom_range(0, hi);
				end else if (sel < 96 && job_bytes + ps <= 18'h3FFFF) begin
					loc = job_bytes + $urandom_range(0, ps);
				end else begin
					loc = $urandom_range(0, 18'h3FFFF);
				end
				send_item(pfat_pkg::MODE_TRANSLATE, pfat_pkg::JOB_ID_W'($urandom),
					pfat_pkg::JOB_SIZE_W'($urandom), pfat_pkg::LOC_W'(loc));
			end
			random_sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values: 100-byte pages, 10 frames, no job loaded
	task automatic test_reset_state();
		send_item(pfat_pkg::MODE_TRANSLATE, pfat_pkg::JOB_ID_W'($urandom),
			pfat_pkg::JOB_SIZE_W'($urandom), '0);
		send_item(pfat_pkg::MODE_LOAD, 16'h0001, '0, pfat_pkg::LOC_W'($urandom)); // empty job
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, '0);                  // nothing in it
		// 3 pages, 50 wasted
		send_item(pfat_pkg::MODE_LOAD, 16'h00A5, 19'd250, pfat_pkg::LOC_W'($urandom));
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd0);
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd249);
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd250);             // one past the end
		send_item(pfat_pkg::MODE_LOAD, 16'h1234, 19'd1000, '0);           // too big, 7 free
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd0);               // job dropped
		send_item(pfat_pkg::MODE_LOAD, 16'h5A5A, 19'd700, '0);            // exact fit
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd699);
	endtask

	// Page size clamps at both ends, full and empty memory, page count
	// saturation and the widest field values
	task automatic test_config_extremes();
		settle();
		write_reg(pfat_pkg::REG_PAGE_SIZE, '0);                  // reads as one byte
		write_reg(pfat_pkg::REG_MEMORY_SIZE, 19'd64);
		send_item(pfat_pkg::MODE_LOAD, 16'hFFFF, 19'd64, '0);
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd63);
		send_item(pfat_pkg::MODE_TRANSLATE, '1, '1, 18'h3FFFF);
		settle();
		write_reg(pfat_pkg::REG_PAGE_SIZE, '1);                  // 8191 clamps to 4096
		write_reg(pfat_pkg::REG_MEMORY_SIZE, 19'd262144);
		send_item(pfat_pkg::MODE_LOAD, 16'h0000, 19'd262144, '1);
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'h3FFFF);  // last byte of last frame
		settle();
		write_reg(pfat_pkg::REG_PAGE_SIZE, 19'd1);
		write_reg(pfat_pkg::REG_MEMORY_SIZE, '1);
		send_item(pfat_pkg::MODE_LOAD, 16'hC3C3, '1, '0);        // page count saturates
		settle();
		write_reg(pfat_pkg::REG_MEMORY_SIZE, '0);                // no frames at all
		send_item(pfat_pkg::MODE_LOAD, 16'h0F0F, '0, '0);
		send_item(pfat_pkg::MODE_LOAD, 16'hF0F0, 19'd1, '0);
		send_item(pfat_pkg::MODE_TRANSLATE, '0, '0, 18'd0);
	endtask

	// Hold the reply side for a long stretch while beats keep coming, so the
	// output register and the engine both fill and the input stalls
	task automatic test_output_backpressure();
		settle();
		write_reg(pfat_pkg::REG_PAGE_SIZE, 19'd16);
		write_reg(pfat_pkg::REG_MEMORY_SIZE, 19'd1024);
		sender_gaps = 1'b0;
		hold_req    = 1'b1;
		run_mixed_items(20);
		sender_gaps = 1'b1;
	endtask

	// Random register settings per phase, random idling on both sides except
	// in an occasional clean phase
	task automatic test_random_traffic();
		bool_phase_loop: while (random_sent < RANDOM_ITEMS) begin
			settle();
			pick_random_config();
			sender_gaps     = ($urandom_range(0, 3) != 0);
			receiver_stalls = ($urandom_range(0, 3) != 0);
			run_mixed_items($urandom_range(20, 60));
		end
	endtask

	// Back-to-back beats with the reply side always ready
	task automatic test_steady_stream();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		settle();
		pick_random_config();
		run_mixed_items(STEADY_ITEMS);
	endtask

	initial begin
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = 1'b0;
		m_tready        = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = pfat_pkg::REG_PAGE_SIZE;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		hold_req        = 1'b0;
		hold_left       = 0;
		stall_left      = 0;
		cycle_count     = 0;
		fail_count      = 0;
		loads_sent      = 0;
		translates_sent = 0;
		cfg_writes      = 0;
		random_sent     = 0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;

		// reset state of the model
		cfg_page_size = pfat_pkg::PAGE_SIZE_W'(pfat_pkg::RESET_PAGE_SIZE);
		cfg_mem_size  = pfat_pkg::MEMORY_SIZE_W'(pfat_pkg::RESET_MEMORY_SIZE);
		job_bytes     = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			page_to_frame[i] = 0;
		rebuild_frames();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_config_extremes();
		test_output_backpressure();
		test_random_traffic();
		test_steady_stream();

		settle();
		$display("covered %0d loads and %0d translates across %0d register writes",
			loads_sent, translates_sent, cfg_writes);
		$display("replies: %0d ok, %0d short of frames, %0d bad location, %0d no job",
			status_seen[pfat_pkg::STATUS_OK], status_seen[pfat_pkg::STATUS_NO_FRAMES],
			status_seen[pfat_pkg::STATUS_BAD_LOCATION],
			status_seen[pfat_pkg::STATUS_NO_JOB]);
		if (fail_count == 0)
			$display("paged_frame_allocator_translator_unit: match");
		else
			$display("paged_frame_allocator_translator_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

### paged_frame_allocator_translator_unit.f
+incdir+rtl
rtl/pfat_pkg.sv
rtl/pfat_div.sv
rtl/paged_frame_allocator_translator_unit.sv
bench/tb_top.sv
